>>> design/tld_pkg.sv
package tld_pkg;

	// Event codes carried in the operation field
	typedef enum logic [1:0] {
		OP_RECV    = 2'd0,
		OP_TX_DONE = 2'd1,
		OP_WRITE   = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	// Control characters
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_SP  = 8'h20;

	// Pending-echo counters
	localparam int PEND_W = 16;
	localparam logic [PEND_W-1:0] NL_LIMIT    = 16'hFFFD;
	localparam logic [PEND_W-1:0] ERASE_LIMIT = 16'hFFFC;

endpackage

>>> design/tld_in_if.sv
interface tld_in_if;
	logic              valid;
	logic              ready;
	tld_pkg::op_t      operation;
	logic [1:0]        terminal;
	logic [7:0]        data_byte;

	modport source (output valid, operation, terminal, data_byte, input ready);
	modport sink   (input valid, operation, terminal, data_byte, output ready);
endinterface

>>> design/tld_out_if.sv
interface tld_out_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       read_valid;
	logic [7:0] read_byte;
	logic       read_last;
	logic       write_accepted;

	modport source (output valid, tx_valid, tx_byte, read_valid, read_byte, read_last,
		write_accepted, input ready);
	modport sink   (input valid, tx_valid, tx_byte, read_valid, read_byte, read_last,
		write_accepted, output ready);
endinterface

>>> design/tld_ram.sv
module tld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; read during write gives old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/tty_line_discipline_top.sv
// Canonical line discipline for a bank of serial terminals.
// Channel cmd carries one event per beat: operation (receive byte, transmit
// done, user write, user read), terminal index and a data byte. Channel res
// returns exactly one result beat per command beat, in order: the byte handed
// to the transmitter (if any), the byte popped by a read with its last flag,
// and whether a user write was taken.
// Per-terminal counters and pointers live in a small control RAM, line and
// echo bytes in two data RAMs. A command reads its terminal's control word on
// the accept edge, computes it and writes it back as it leaves the first stage
// (forwarded to a following command on the same terminal); its result beat is
// registered into the result stage, with read data taken straight from the
// data RAM. Throughput is one command per cycle while res is ready; the control
// RAM read-modify-write loop is closed by a one-entry forwarding register.
// When res stalls, the result beat holds; one more command can be taken into
// the first stage, then cmd.ready drops until res drains.
// Reset clears all terminal state at once through per-terminal valid bits;
// there is no clearing pass, and commands are accepted right after reset.
module tty_line_discipline_top #(
	parameter int TERMINALS  = 4,
	parameter int LINE_DEPTH = 4096,
	parameter int ECHO_DEPTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	tld_in_if.sink         cmd,
	tld_out_if.source      res
);

	localparam int TW  = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
	localparam int LPW = $clog2(LINE_DEPTH);
	localparam int LCW = $clog2(LINE_DEPTH + 1);
	localparam int EPW = $clog2(ECHO_DEPTH);
	localparam int ECW = $clog2(ECHO_DEPTH + 1);
	localparam int LAW = $clog2(TERMINALS * LINE_DEPTH);
	localparam int EAW = $clog2(TERMINALS * ECHO_DEPTH);

	typedef struct packed {
		logic [LCW-1:0]            lsc;
		logic [LCW-1:0]            olc;
		logic [LPW-1:0]            lwp;
		logic [LPW-1:0]            lrp;
		logic [ECW-1:0]            ec;
		logic [EPW-1:0]            ewp;
		logic [EPW-1:0]            erp;
		logic [tld_pkg::PEND_W-1:0] np;
		logic [tld_pkg::PEND_W-1:0] ep;
		logic [1:0]                eph;
		logic                      sv;
		logic [7:0]                sb;
		logic                      cr;
		logic                      busy;
	} ctl_t;

	localparam int CTW = $bits(ctl_t);

	// Pipeline handshake
	logic         v_s1, v_s2;
	logic         adv1, adv2, acc;
	tld_pkg::op_t op_s1;
	logic [1:0]   term_s1;
	logic [7:0]   byte_s1;

	assign adv2      = !v_s2 || res.ready;
	assign adv1      = v_s1 && adv2;
	assign cmd.ready = !v_s1 || adv2;
	assign acc       = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (acc)
				v_s1 <= 1'b1;
			else if (adv1)
				v_s1 <= 1'b0;
			if (adv1)
				v_s2 <= 1'b1;
			else if (res.ready)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1   <= cmd.operation;
			term_s1 <= cmd.terminal;
			byte_s1 <= cmd.data_byte;
		end
	end

	// Control RAM with per-terminal valid bits and write-back forwarding
	logic [TW-1:0]  tidx_s1;
	logic           in_rng_s1;
	logic [CTW-1:0] ctl_rdata;
	logic [TERMINALS-1:0] vld_q;
	logic           wb_v_q;
	logic [TW-1:0]  wb_t_q;
	ctl_t           wb_d_q;
	ctl_t           st, nx;
	logic           ctl_we;

	assign tidx_s1   = TW'(term_s1);
	assign in_rng_s1 = 32'(term_s1) < TERMINALS;
	assign ctl_we    = adv1 && in_rng_s1;

	tld_ram #(.WIDTH(CTW), .DEPTH(TERMINALS)) u_ctl_ram (
		.clk   (clk),
		.we    (ctl_we),
		.waddr (tidx_s1),
		.wdata (CTW'(nx)),
		.re    (acc),
		.raddr (TW'(cmd.terminal)),
		.rdata (ctl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			wb_v_q <= 1'b0;
		end else if (ctl_we) begin
			vld_q[tidx_s1] <= 1'b1;
			wb_v_q         <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_we) begin
			wb_t_q <= tidx_s1;
			wb_d_q <= nx;
		end
	end

	always_comb begin
		if (wb_v_q && wb_t_q == tidx_s1)
			st = wb_d_q;
		else if (vld_q[tidx_s1])
			st = ctl_t'(ctl_rdata);
		else
			st = '0;
	end

	// Edit and transmit step
	logic           line_we, echo_we, echo_first;
	logic [7:0]     line_wd, echo_wd;
	logic           txv, tx_ram, rd_v, rd_empty, wacc;
	logic [7:0]     txb;

	always_comb begin
		logic do_tx;
		logic lpush;
		logic [7:0] lbyte;
		logic epush;
		logic [7:0] ebyte;
		nx         = st;
		line_we    = 1'b0;
		line_wd    = '0;
		echo_we    = 1'b0;
		echo_wd    = '0;
		echo_first = 1'b0;
		txv        = 1'b0;
		tx_ram     = 1'b0;
		txb        = '0;
		rd_v       = 1'b0;
		rd_empty   = 1'b0;
		wacc       = 1'b0;
		do_tx      = 1'b0;
		lpush      = 1'b0;
		lbyte      = '0;
		epush      = 1'b0;
		ebyte      = '0;

		case (op_s1)
			tld_pkg::OP_RECV: begin
				if (byte_s1 == tld_pkg::CH_CR) begin
					if (st.lsc >= LCW'(LINE_DEPTH)) begin
						nx.olc = '0;
					end else begin
						lpush = 1'b1;
						lbyte = tld_pkg::CH_LF;
					end
					if (st.np <= tld_pkg::NL_LIMIT)
						nx.np = st.np + 16'd2;
				end else if (byte_s1 == tld_pkg::CH_BS || byte_s1 == tld_pkg::CH_DEL) begin
					if (st.olc != '0) begin
						nx.lsc = st.lsc - 1'b1;
						nx.olc = st.olc - 1'b1;
						nx.lwp = (st.lwp == '0) ? LPW'(LINE_DEPTH - 1) : st.lwp - 1'b1;
						if (st.ep <= tld_pkg::ERASE_LIMIT)
							nx.ep = st.ep + 16'd3;
					end else begin
						epush = 1'b1;
						ebyte = tld_pkg::CH_BEL;
					end
				end else if (st.lsc < LCW'(LINE_DEPTH)) begin
					lpush = 1'b1;
					lbyte = byte_s1;
					epush = 1'b1;
					ebyte = byte_s1;
				end else begin
					epush = 1'b1;
					ebyte = tld_pkg::CH_BEL;
				end
				do_tx = !st.busy;
			end
			tld_pkg::OP_TX_DONE: begin
				do_tx = 1'b1;
			end
			tld_pkg::OP_WRITE: begin
				if (!st.sv) begin
					nx.sv = 1'b1;
					nx.sb = byte_s1;
					wacc  = 1'b1;
					do_tx = !st.busy;
				end
			end
			tld_pkg::OP_READ: begin
				if (st.lsc != st.olc) begin
					rd_v     = 1'b1;
					nx.lsc   = st.lsc - 1'b1;
					rd_empty = (st.lsc == LCW'(1));
					nx.lrp   = (st.lrp == LPW'(LINE_DEPTH - 1)) ? '0 : st.lrp + 1'b1;
				end
			end
			default: begin
				do_tx = 1'b0;
			end
		endcase

		// Line store push; callers have checked for room
		if (lpush) begin
			line_we = 1'b1;
			line_wd = lbyte;
			nx.lsc  = st.lsc + 1'b1;
			nx.olc  = (lbyte == tld_pkg::CH_LF) ? '0 : st.olc + 1'b1;
			nx.lwp  = (st.lwp == LPW'(LINE_DEPTH - 1)) ? '0 : st.lwp + 1'b1;
		end

		// Echo queue push; dropped when full
		if (epush && st.ec < ECW'(ECHO_DEPTH)) begin
			echo_we    = 1'b1;
			echo_wd    = ebyte;
			echo_first = (st.ec == '0);
			nx.ec      = st.ec + 1'b1;
			nx.ewp     = (st.ewp == EPW'(ECHO_DEPTH - 1)) ? '0 : st.ewp + 1'b1;
		end

		// Transmitter: CR-LF, erase, echo, then user slot
		if (do_tx) begin
			txv = 1'b1;
			if (nx.np != '0) begin
				txb   = nx.np[0] ? tld_pkg::CH_LF : tld_pkg::CH_CR;
				nx.np = nx.np - 1'b1;
			end else if (nx.ep != '0) begin
				txb    = (nx.eph == 2'd2) ? tld_pkg::CH_SP : tld_pkg::CH_BS;
				nx.ep  = nx.ep - 1'b1;
				nx.eph = (nx.eph == 2'd0) ? 2'd2 : nx.eph - 2'd1;
			end else if (nx.ec != '0) begin
				if (echo_first)
					txb = echo_wd;
				else
					tx_ram = 1'b1;
				nx.ec  = nx.ec - 1'b1;
				nx.erp = (st.erp == EPW'(ECHO_DEPTH - 1)) ? '0 : st.erp + 1'b1;
			end else if (nx.sv) begin
				if (nx.sb == tld_pkg::CH_LF && !nx.cr) begin
					txb   = tld_pkg::CH_CR;
					nx.cr = 1'b1;
				end else begin
					if (nx.sb == tld_pkg::CH_LF)
						nx.cr = 1'b0;
					nx.sv = 1'b0;
					txb   = nx.sb;
				end
			end else begin
				txv = 1'b0;
			end
			nx.busy = txv;
		end

		// Out-of-range terminal: nothing happens
		if (!in_rng_s1) begin
			line_we = 1'b0;
			echo_we = 1'b0;
			txv     = 1'b0;
			tx_ram  = 1'b0;
			rd_v    = 1'b0;
			wacc    = 1'b0;
		end
	end

	// Data RAMs: line and echo bytes for all terminals
	logic [7:0] line_rdata, echo_rdata;
	logic [LAW-1:0] line_base;
	logic [EAW-1:0] echo_base;

	assign line_base = LAW'(32'(tidx_s1) * LINE_DEPTH);
	assign echo_base = EAW'(32'(tidx_s1) * ECHO_DEPTH);

	tld_ram #(.WIDTH(8), .DEPTH(TERMINALS * LINE_DEPTH)) u_line_ram (
		.clk   (clk),
		.we    (adv1 && line_we),
		.waddr (line_base + LAW'(st.lwp)),
		.wdata (line_wd),
		.re    (adv1),
		.raddr (line_base + LAW'(st.lrp)),
		.rdata (line_rdata)
	);

	tld_ram #(.WIDTH(8), .DEPTH(TERMINALS * ECHO_DEPTH)) u_echo_ram (
		.clk   (clk),
		.we    (adv1 && echo_we),
		.waddr (echo_base + EAW'(st.ewp)),
		.wdata (echo_wd),
		.re    (adv1),
		.raddr (echo_base + EAW'(st.erp)),
		.rdata (echo_rdata)
	);

	// Result stage
	logic       txv_s2, tx_ram_s2, rd_v_s2, rd_empty_s2, wacc_s2;
	logic [7:0] txb_s2;

	always_ff @(posedge clk) begin
		if (adv1) begin
			txv_s2      <= txv;
			tx_ram_s2   <= tx_ram;
			txb_s2      <= txb;
			rd_v_s2     <= rd_v;
			rd_empty_s2 <= rd_empty;
			wacc_s2     <= wacc;
		end
	end

	assign res.valid          = v_s2;
	assign res.tx_valid       = txv_s2;
	assign res.tx_byte        = !txv_s2 ? 8'd0 : (tx_ram_s2 ? echo_rdata : txb_s2);
	assign res.read_valid     = rd_v_s2;
	assign res.read_byte      = rd_v_s2 ? line_rdata : 8'd0;
	assign res.read_last      = rd_v_s2 && (line_rdata == tld_pkg::CH_LF || rd_empty_s2);
	assign res.write_accepted = wacc_s2;

endmodule
